@@ hdl/mwt_pkg.sv @@
`timescale 1ns / 1ps

package mwt_pkg;

    localparam logic [15:0] ADDR_MASK    = 16'hF0F0;
    localparam logic [15:0] GRP_RESET    = 16'hA000;
    localparam logic [15:0] GRP_LATCH    = 16'hA010;
    localparam logic [15:0] GRP_X_LO     = 16'hA020;
    localparam logic [15:0] GRP_X_HI     = 16'hA030;
    localparam logic [15:0] GRP_Y_LO     = 16'hA040;
    localparam logic [15:0] GRP_Y_HI     = 16'hA050;
    localparam logic [15:0] GRP_PORT     = 16'hA080;

    localparam logic [7:0]  CMD_RESET    = 8'h55;
    localparam logic [7:0]  CMD_LATCH    = 8'hAA;
    localparam logic [7:0]  BYTE_IDLE    = 8'hFF;

    localparam logic [15:0] TILT_RESET   = 16'h8000;
    localparam logic [15:0] TILT_CENTRE  = 16'h81D0;

    localparam logic [15:0] WORD_ERASED  = 16'hFFFF;
    localparam logic [15:0] WORD_CLEAR   = 16'h0000;
    localparam logic [4:0]  DATA_BITS    = 5'd16;

    localparam logic [3:0]  OP_EWDS      = 4'h0;
    localparam logic [3:0]  OP_WRAL      = 4'h1;
    localparam logic [3:0]  OP_ERAL      = 4'h2;
    localparam logic [3:0]  OP_EWEN      = 4'h3;
    localparam logic [3:0]  OP_WRITE_LO  = 4'h4;
    localparam logic [3:0]  OP_WRITE_HI  = 4'h7;
    localparam logic [3:0]  OP_READ_LO   = 4'h8;
    localparam logic [3:0]  OP_READ_HI   = 4'hB;
    localparam logic [3:0]  OP_ERASE_LO  = 4'hC;
    localparam logic [3:0]  OP_ERASE_HI  = 4'hF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SWEEP
    } mwt_state_t;

    typedef struct packed {
        logic cs;
        logic clk;
        logic di;
        logic dout;
    } mwt_pins_t;

endpackage

@@ hdl/microwire_eeprom_tilt_registers_top.sv @@
`timescale 1ns / 1ps

// Tilt-sensor cartridge registers with a bit-banged serial EEPROM of
// EEPROM_WORDS 16-bit words. A bus word is accepted while the EEPROM is idle
// and the output register is free or being emptied; a read result appears in
// the output register on the next cycle. A port write that completes a READ
// command holds off the next word while the EEPROM memory is read. ERAL, the
// start of WRAL and every WRAL data bit of one rewrite the whole store through
// the single memory write port, and no word is accepted during that sweep.
// After reset the same erase sweep runs before the first word is taken.

module microwire_eeprom_tilt_registers_top
    import mwt_pkg::*;
#(
    parameter int EEPROM_WORDS = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [15:0]        address,
    input  logic [7:0]         write_data,
    input  logic               access_enabled,
    input  logic signed [11:0] tilt_dx,
    input  logic signed [11:0] tilt_dy,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         read_data
);

    logic [15:0] tilt_x_reg, tilt_x_next;
    logic [15:0] tilt_y_reg, tilt_y_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;

    logic        busy;
    mwt_pins_t   pins;
    logic        accept;
    logic [15:0] group;
    logic        port_wr;
    logic [7:0]  rd_byte;

    mwt_eeprom #(
        .EEPROM_WORDS (EEPROM_WORDS)
    ) u_eeprom (
        .clk       (clk),
        .rst_n     (rst_n),
        .port_wr   (port_wr),
        .port_data (write_data),
        .busy      (busy),
        .pins      (pins)
    );

    assign in_ready = !busy && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign group    = address & ADDR_MASK;
    assign port_wr  = accept && req_type && access_enabled && (group == GRP_PORT);

    always_comb
    begin
        rd_byte = BYTE_IDLE;
        if (access_enabled)
        begin
            case (group)
                GRP_X_LO: rd_byte = tilt_x_reg[7:0];
                GRP_X_HI: rd_byte = tilt_x_reg[15:8];
                GRP_Y_LO: rd_byte = tilt_y_reg[7:0];
                GRP_Y_HI: rd_byte = tilt_y_reg[15:8];
                GRP_PORT: rd_byte = {pins.cs, pins.clk, 4'b0000, pins.di, pins.dout};
                default:  rd_byte = BYTE_IDLE;
            endcase
        end
    end

    always_comb
    begin
        tilt_x_next    = tilt_x_reg;
        tilt_y_next    = tilt_y_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (!req_type)
            begin
                out_valid_next = 1'b1;
                out_data_next  = rd_byte;
            end
            else if (access_enabled)
            begin
                if ((group == GRP_RESET) && (write_data == CMD_RESET))
                begin
                    tilt_x_next = TILT_RESET;
                    tilt_y_next = TILT_RESET;
                end
                else if ((group == GRP_LATCH) && (write_data == CMD_LATCH))
                begin
                    tilt_x_next = TILT_CENTRE + {{4{tilt_dx[11]}}, tilt_dx};
                    tilt_y_next = TILT_CENTRE + {{4{tilt_dy[11]}}, tilt_dy};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_x_reg    <= '0;
            tilt_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tilt_x_reg    <= tilt_x_next;
            tilt_y_reg    <= tilt_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;

endmodule

@@ hdl/mwt_ram.sv @@
`timescale 1ns / 1ps

module mwt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/mwt_eeprom.sv @@
`timescale 1ns / 1ps

module mwt_eeprom
    import mwt_pkg::*;
#(
    parameter int EEPROM_WORDS = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      port_wr,
    input  logic [7:0] port_data,
    output logic      busy,
    output mwt_pins_t pins
);

    localparam int AW = $clog2(EEPROM_WORDS);
    localparam logic [7:0]    WORDS8 = 8'(EEPROM_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(EEPROM_WORDS - 1);

    mwt_state_t state_reg, state_next;

    logic [10:0]   cmd_reg, cmd_next;
    logic [15:0]   rshift_reg, rshift_next;
    logic [4:0]    bits_reg, bits_next;
    logic          dout_reg, dout_next;
    logic          di_reg, di_next;
    logic          clk_reg, clk_next;
    logic          cs_reg, cs_next;
    logic [15:0]   wval_reg, wval_next;
    logic [15:0]   fill_reg, fill_next;
    logic [AW-1:0] sweep_addr_reg, sweep_addr_next;

    logic [10:0]   cmd_sel;
    logic [3:0]    opcode;
    logic [7:0]    idx_wide;
    logic [AW-1:0] idx;
    logic [4:0]    bit_pos;
    logic          rise;
    logic          op_write;
    logic [15:0]   op_wdata;
    logic          op_load;
    logic          op_sweep;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    mwt_ram #(
        .WIDTH (16),
        .DEPTH (EEPROM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // serial port and command decode
    always_comb
    begin
        cmd_next    = cmd_reg;
        rshift_next = rshift_reg;
        bits_next   = bits_reg;
        dout_next   = dout_reg;
        di_next     = di_reg;
        clk_next    = clk_reg;
        cs_next     = cs_reg;
        wval_next   = wval_reg;
        fill_next   = fill_reg;
        op_write    = 1'b0;
        op_wdata    = WORD_CLEAR;
        op_load     = 1'b0;
        op_sweep    = 1'b0;

        cmd_sel  = (bits_reg == 5'd0) ? {cmd_reg[9:0], port_data[1]} : cmd_reg;
        opcode   = cmd_sel[9:6];
        idx_wide = {1'b0, cmd_sel[6:0]};
        if (idx_wide >= WORDS8)
        begin
            idx_wide = idx_wide - WORDS8;
        end
        idx     = idx_wide[AW-1:0];
        bit_pos = bits_reg - 5'd1;
        rise    = port_data[7] && !clk_reg && port_data[6];

        if (state_reg == ST_LOAD)
        begin
            rshift_next = ram_rdata;
        end

        if (port_wr)
        begin
            cs_next  = port_data[7];
            di_next  = port_data[1];
            clk_next = port_data[6];
            if (rise)
            begin
                dout_next   = rshift_reg[15];
                rshift_next = {rshift_reg[14:0], 1'b1};
                if (bits_reg == 5'd0)
                begin
                    cmd_next = cmd_sel;
                    if (cmd_sel[10])
                    begin
                        if (opcode inside {[OP_READ_LO:OP_READ_HI]})
                        begin
                            op_load  = 1'b1;
                            cmd_next = '0;
                        end
                        else if (opcode inside {[OP_WRITE_LO:OP_WRITE_HI]})
                        begin
                            op_write  = 1'b1;
                            op_wdata  = WORD_CLEAR;
                            wval_next = WORD_CLEAR;
                            bits_next = DATA_BITS;
                        end
                        else if (opcode inside {[OP_ERASE_LO:OP_ERASE_HI]})
                        begin
                            op_write = 1'b1;
                            op_wdata = WORD_ERASED;
                            cmd_next = '0;
                        end
                        else if (opcode == OP_ERAL)
                        begin
                            op_sweep  = 1'b1;
                            fill_next = WORD_ERASED;
                            cmd_next  = '0;
                        end
                        else if (opcode == OP_WRAL)
                        begin
                            op_sweep  = 1'b1;
                            fill_next = WORD_CLEAR;
                            wval_next = WORD_CLEAR;
                            bits_next = DATA_BITS;
                        end
                        else
                        begin
                            cmd_next = '0;
                        end
                    end
                end
                else
                begin
                    bits_next = bit_pos;
                    dout_next = 1'b1;
                    if (port_data[1])
                    begin
                        wval_next = wval_reg | (16'd1 << bit_pos[3:0]);
                        if (cmd_reg[8])
                        begin
                            op_write = 1'b1;
                            op_wdata = wval_next;
                        end
                        else
                        begin
                            op_sweep  = 1'b1;
                            fill_next = wval_next;
                        end
                    end
                    if (bit_pos == 5'd0)
                    begin
                        cmd_next = '0;
                    end
                end
            end
        end
    end

    // next state
    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (op_sweep)
                begin
                    state_next = ST_SWEEP;
                end
                else if (op_load)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (sweep_addr_reg == LAST_ADDR)
                begin
                    sweep_addr_next = '0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory controls
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx;
        ram_wdata = op_wdata;
        ram_re    = 1'b0;
        ram_raddr = idx;
        case (state_reg)
            ST_IDLE:
            begin
                ram_we = op_write;
                ram_re = op_load;
            end
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_addr_reg;
                ram_wdata = fill_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // reset starts with an erase sweep over the whole store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            fill_reg       <= WORD_ERASED;
            cmd_reg        <= '0;
            rshift_reg     <= '0;
            bits_reg       <= '0;
            dout_reg       <= 1'b0;
            di_reg         <= 1'b0;
            clk_reg        <= 1'b0;
            cs_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            fill_reg       <= fill_next;
            cmd_reg        <= cmd_next;
            rshift_reg     <= rshift_next;
            bits_reg       <= bits_next;
            dout_reg       <= dout_next;
            di_reg         <= di_next;
            clk_reg        <= clk_next;
            cs_reg         <= cs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wval_reg <= wval_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign pins.cs   = cs_reg;
    assign pins.clk  = clk_reg;
    assign pins.di   = di_reg;
    assign pins.dout = dout_reg;

endmodule
